// ----- design/cta_pkg.sv -----
package cta_pkg;

    // Operation codes carried in the func field.
    typedef enum logic [4:0] {
        F_ADD  = 5'd0,  F_SUB  = 5'd1,  F_MUL  = 5'd2,  F_SDIV = 5'd3,
        F_SREM = 5'd4,  F_UDIV = 5'd5,  F_UREM = 5'd6,  F_AND  = 5'd7,
        F_OR   = 5'd8,  F_XOR  = 5'd9,  F_SHL  = 5'd10, F_LSHR = 5'd11,
        F_ASHR = 5'd12, F_EQ   = 5'd13, F_NE   = 5'd14, F_SLT  = 5'd15,
        F_SLE  = 5'd16, F_SGT  = 5'd17, F_SGE  = 5'd18, F_ULT  = 5'd19,
        F_ULE  = 5'd20, F_UGT  = 5'd21, F_UGE  = 5'd22
    } t_func;

    // Operand width codes.
    typedef enum logic [1:0] {
        W_16 = 2'd0, W_32 = 2'd1, W_64 = 2'd2, W_64_ALT = 2'd3
    } t_width;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV_ZERO = 2'd2, ST_DIV_OVF = 2'd3
    } t_status;

    localparam int unsigned C_XLEN      = 64;
    localparam int unsigned C_HALF      = C_XLEN / 2;
    // One divider bit per stage, plus input, prepare and finish stages.
    localparam int unsigned C_NSTG      = C_XLEN + 3;
    localparam int unsigned C_MUL_PP    = 1;
    localparam int unsigned C_MUL_MID   = 2;
    localparam int unsigned C_MUL_SUM   = 3;
    localparam int unsigned C_MUL_FIN   = 4;
    localparam int unsigned C_FIN_STEP  = C_XLEN + 1;

    // Everything that travels down the pipeline with one word.
    typedef struct packed {
        logic [4:0]          func;
        logic [1:0]          wsel;
        logic [C_XLEN-1:0]   a;
        logic [C_XLEN-1:0]   b;
        logic [C_XLEN-1:0]   res;
        t_status             st;
        logic                neg_q;
        logic                neg_r;
        logic                mneg;
        logic [C_XLEN-1:0]   ma;
        logic [C_XLEN-1:0]   mb;
        logic [C_XLEN-1:0]   pp_ll;
        logic [C_XLEN-1:0]   pp_lh;
        logic [C_XLEN-1:0]   pp_hl;
        logic [C_XLEN-1:0]   pp_hh;
        logic [C_XLEN:0]     mid;
        logic [2*C_XLEN-1:0] prod;
        logic [C_XLEN-1:0]   rem;
        logic [C_XLEN-1:0]   quo;
        logic [C_XLEN-1:0]   dvs;
    } t_pipe;

    function automatic logic [63:0] sext_w(logic [63:0] v, logic [1:0] w);
        unique case (t_width'(w))
            W_16:    return {{48{v[15]}}, v[15:0]};
            W_32:    return {{32{v[31]}}, v[31:0]};
            default: return v;
        endcase
    endfunction

    function automatic logic [63:0] zext_w(logic [63:0] v, logic [1:0] w);
        unique case (t_width'(w))
            W_16:    return {48'd0, v[15:0]};
            W_32:    return {32'd0, v[31:0]};
            default: return v;
        endcase
    endfunction

    function automatic logic [5:0] amt_w(logic [63:0] v, logic [1:0] w);
        unique case (t_width'(w))
            W_16:    return {2'd0, v[3:0]};
            W_32:    return {1'b0, v[4:0]};
            default: return v[5:0];
        endcase
    endfunction

    function automatic logic [63:0] smin_w(logic [1:0] w);
        unique case (t_width'(w))
            W_16:    return {{49{1'b1}}, 15'd0};
            W_32:    return {{33{1'b1}}, 31'd0};
            default: return {1'b1, 63'd0};
        endcase
    endfunction

    function automatic logic [63:0] mag(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Decode the operands and compute every operation other than multiply and divide.
    function automatic t_pipe prep(t_pipe p);
        t_pipe       n;
        logic [63:0] sa, sb, ua, ub, sum;
        logic [5:0]  amt;
        n = p;
        sa = sext_w(p.a, p.wsel);
        sb = sext_w(p.b, p.wsel);
        ua = zext_w(p.a, p.wsel);
        ub = zext_w(p.b, p.wsel);
        amt = amt_w(p.b, p.wsel);
        n.res = 64'd0;
        n.st = ST_OK;
        n.neg_q = 1'b0;
        n.neg_r = 1'b0;
        n.mneg = p.a[63] ^ p.b[63];
        n.ma = mag(p.a);
        n.mb = mag(p.b);
        n.rem = 64'd0;
        n.quo = ua;
        n.dvs = ub;
        unique case (p.func)
            F_ADD: begin
                sum = p.a + p.b;
                n.res = sum;
                if (((p.a ^ sum) & (p.b ^ sum)) >> 63 != 64'd0) n.st = ST_OVF;
            end
            F_SUB: begin
                sum = p.a - p.b;
                n.res = sum;
                if (((p.a ^ p.b) & (p.a ^ sum)) >> 63 != 64'd0) n.st = ST_OVF;
            end
            F_SDIV, F_SREM: begin
                n.quo = mag(sa);
                n.dvs = mag(sb);
                n.neg_q = sa[63] ^ sb[63];
                n.neg_r = sa[63];
                if (sb == 64'd0) n.st = ST_DIV_ZERO;
                else if (sa == smin_w(p.wsel) && sb == {64{1'b1}}) n.st = ST_DIV_OVF;
            end
            F_UDIV, F_UREM: begin
                if (ub == 64'd0) n.st = ST_DIV_ZERO;
            end
            F_AND:  n.res = p.a & p.b;
            F_OR:   n.res = p.a | p.b;
            F_XOR:  n.res = p.a ^ p.b;
            F_SHL:  n.res = ua << amt;
            F_LSHR: n.res = ua >> amt;
            F_ASHR: n.res = $unsigned($signed(sa) >>> amt);
            F_EQ:   n.res = {63'd0, p.a == p.b};
            F_NE:   n.res = {63'd0, p.a != p.b};
            F_SLT:  n.res = {63'd0, $signed(p.a) <  $signed(p.b)};
            F_SLE:  n.res = {63'd0, $signed(p.a) <= $signed(p.b)};
            F_SGT:  n.res = {63'd0, $signed(p.a) >  $signed(p.b)};
            F_SGE:  n.res = {63'd0, $signed(p.a) >= $signed(p.b)};
            F_ULT:  n.res = {63'd0, p.a <  p.b};
            F_ULE:  n.res = {63'd0, p.a <= p.b};
            F_UGT:  n.res = {63'd0, p.a >  p.b};
            F_UGE:  n.res = {63'd0, p.a >= p.b};
            default: n.res = 64'd0;
        endcase
        return n;
    endfunction

    // One restoring division step: one quotient bit.
    function automatic t_pipe div_step(t_pipe p);
        t_pipe       n;
        logic [64:0] sh, tr;
        n = p;
        sh = {p.rem, p.quo[63]};
        tr = sh - {1'b0, p.dvs};
        if (!tr[64]) begin
            n.rem = tr[63:0];
            n.quo = {p.quo[62:0], 1'b1};
        end else begin
            n.rem = sh[63:0];
            n.quo = {p.quo[62:0], 1'b0};
        end
        return n;
    endfunction

    // Signed 64-bit product and overflow check from the magnitude product.
    function automatic t_pipe mul_fin(t_pipe p);
        t_pipe       n;
        logic [63:0] limit;
        n = p;
        if (p.func == F_MUL) begin
            limit = p.mneg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            n.res = p.mneg ? (64'd0 - p.prod[63:0]) : p.prod[63:0];
            if (p.prod[127:64] != 64'd0 || p.prod[63:0] > limit) n.st = ST_OVF;
        end
        return n;
    endfunction

    // Pick the divider result, check the width, zero the value of a faulted word and sign-extend the rest.
    function automatic t_pipe finish(t_pipe p);
        t_pipe       n;
        logic [63:0] r;
        n = p;
        r = p.res;
        unique case (p.func)
            F_SDIV:  r = p.neg_q ? (64'd0 - p.quo) : p.quo;
            F_SREM:  r = p.neg_r ? (64'd0 - p.rem) : p.rem;
            F_UDIV:  r = p.quo;
            F_UREM:  r = p.rem;
            default: r = p.res;
        endcase
        if (n.st == ST_OK && p.func <= F_MUL && sext_w(r, p.wsel) != r) n.st = ST_OVF;
        if (n.st != ST_OK) r = 64'd0;
        else if (p.func <= F_ASHR) r = sext_w(r, p.wsel);
        n.res = r;
        return n;
    endfunction

    // Work done between stage k and stage k+1.
    function automatic t_pipe stage_next(int unsigned k, t_pipe p);
        t_pipe n;
        n = p;
        if (k == 0) begin
            n = prep(p);
        end else if (k <= C_XLEN) begin
            n = div_step(p);
            if (k == C_MUL_PP) begin
                n.pp_ll = p.ma[C_HALF-1:0] * p.mb[C_HALF-1:0];
                n.pp_lh = p.ma[C_HALF-1:0] * p.mb[C_XLEN-1:C_HALF];
                n.pp_hl = p.ma[C_XLEN-1:C_HALF] * p.mb[C_HALF-1:0];
                n.pp_hh = p.ma[C_XLEN-1:C_HALF] * p.mb[C_XLEN-1:C_HALF];
            end else if (k == C_MUL_MID) begin
                n.mid = {1'b0, p.pp_lh} + {1'b0, p.pp_hl};
            end else if (k == C_MUL_SUM) begin
                n.prod = {p.pp_hh, p.pp_ll} + ({63'd0, p.mid} << C_HALF);
            end else if (k == C_MUL_FIN) begin
                n = mul_fin(n);
            end
        end else if (k == C_FIN_STEP) begin
            n = finish(p);
        end
        return n;
    endfunction

endpackage

// ----- design/cta_if.sv -----
// Operation word channel.
interface cta_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  func;
    logic [1:0]  width_sel;
    logic [63:0] lhs_value;
    logic [63:0] rhs_value;
    modport source (output valid, func, width_sel, lhs_value, rhs_value, input ready);
    modport sink   (input valid, func, width_sel, lhs_value, rhs_value, output ready);
endinterface

// Result word channel.
interface cta_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_value;
    logic [1:0]  status;
    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

// ----- design/checked_typed_integer_alu.sv -----
// Checked integer ALU. Takes one operation word per cycle while the output
// is not stalled and returns one result word per operation, in order. The
// divider resolves one quotient bit per pipeline stage over 64 stages; all
// other operations ride along in the same stages. Throughput is one word per
// cycle while the output is not stalled. A stall on the output freezes the
// whole pipeline and drops input ready.
module checked_typed_integer_alu (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cta_in_if.sink     i_word,
    cta_out_if.source  o_word
);
    import cta_pkg::*;

    t_pipe r_p [C_NSTG];
    logic  r_v [C_NSTG];
    logic  en;
    t_pipe n_in;

    // The pipeline moves whenever the output register is free or drained.
    assign en = !r_v[C_NSTG-1] || o_word.ready;
    assign i_word.ready = en;

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < C_NSTG; i++) r_v[i] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_word.valid;
            for (int i = 1; i < C_NSTG; i++) r_v[i] <= r_v[i-1];
        end
    end

    // Assemble the incoming word with all derived fields cleared.
    always_comb begin
        n_in      = '0;
        n_in.func = i_word.func;
        n_in.wsel = i_word.width_sel;
        n_in.a    = i_word.lhs_value;
        n_in.b    = i_word.rhs_value;
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= n_in;
        end
    end

    // Prepare, divide and multiply, finish.
    for (genvar k = 0; k < C_NSTG - 1; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p[k+1] <= stage_next(k, r_p[k]);
            end
        end
    end

    assign o_word.valid        = r_v[C_NSTG-1];
    assign o_word.result_value = r_p[C_NSTG-1].res;
    assign o_word.status       = r_p[C_NSTG-1].st;

endmodule

// ----- design/cta_checker.sv -----
module cta_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        o_valid,
    input logic        o_ready,
    input logic [63:0] o_result_value,
    input logic [1:0]  o_status
);
    import cta_pkg::*;

    // A faulted word always carries a zero value.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_result_value == 64'd0)
        else $error("faulted word with nonzero value");

    // An empty output means the input side is open.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> i_ready)
        else $error("input blocked while output is empty");

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output word right after reset");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ready) |=> (o_valid && $stable(o_result_value)
                                   && $stable(o_status)))
        else $error("stalled result word changed");

endmodule

bind checked_typed_integer_alu cta_checker u_cta_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_word.valid),
    .i_ready        (i_word.ready),
    .o_valid        (o_word.valid),
    .o_ready        (o_word.ready),
    .o_result_value (o_word.result_value),
    .o_status       (o_word.status)
);

// ----- test/checked_typed_integer_alu_test.sv -----
`timescale 1ns / 1ps

module checked_typed_integer_alu_test;
    import cta_pkg::*;

    typedef struct {
        logic [4:0]  func;
        logic [1:0]  wsel;
        logic [63:0] lhs;
        logic [63:0] rhs;
    } t_op;

    typedef struct {
        logic [63:0] value;
        t_status     st;
    } t_res;

    localparam int unsigned LATENCY   = 67;
    localparam int unsigned WATCHDOG  = 4000;
    localparam int unsigned N_RANDOM  = 1630;
    localparam logic [63:0] MIN64     = {1'b1, 63'd0};
    localparam logic [63:0] MAX64     = {1'b0, {63{1'b1}}};
    localparam logic [63:0] ONES      = {64{1'b1}};

    logic i_clk;
    logic i_rst_n;
    cta_in_if  op_ch ();
    cta_out_if res_ch ();

    t_op  op_queue[$];
    t_res result_queue[$];
    int   fail_count;
    int   idle_cycles;
    bit   hold_sender;

    checked_typed_integer_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (op_ch.sink),
        .o_word  (res_ch.source)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned width_of(logic [1:0] w);
        if (w == W_16) return 16;
        if (w == W_32) return 32;
        return 64;
    endfunction

    function automatic logic [63:0] sign_ext(logic [63:0] v, int unsigned bits);
        if (bits >= 64) return v;
        return (v << (64 - bits)) >>> 0 == 0 ? 64'd0
            : 64'($signed(v << (64 - bits)) >>> (64 - bits));
    endfunction

    function automatic logic [63:0] zero_ext(logic [63:0] v, int unsigned bits);
        if (bits >= 64) return v;
        return v & ((64'd1 << bits) - 64'd1);
    endfunction

    function automatic logic [63:0] absval(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Computes the checked ALU result for one operation.
    function automatic t_res alu_result(t_op op);
        t_res        r;
        int unsigned bits;
        logic [63:0] sa, sb, ua, ub, smin, res, q, rm, lim;
        logic [127:0] prod;
        logic [5:0]  amt;
        logic        neg;
        bits = width_of(op.wsel);
        sa = sign_ext(op.lhs, bits);
        sb = sign_ext(op.rhs, bits);
        ua = zero_ext(op.lhs, bits);
        ub = zero_ext(op.rhs, bits);
        smin = sign_ext(64'd1 << (bits - 1), bits);
        amt = 6'(op.rhs & 64'(bits - 1));
        res = 64'd0;
        r.st = ST_OK;
        case (op.func)
            F_ADD: begin
                res = op.lhs + op.rhs;
                if (((op.lhs ^ res) & (op.rhs ^ res)) >> 63) r.st = ST_OVF;
            end
            F_SUB: begin
                res = op.lhs - op.rhs;
                if (((op.lhs ^ op.rhs) & (op.lhs ^ res)) >> 63) r.st = ST_OVF;
            end
            F_MUL: begin
                neg = op.lhs[63] ^ op.rhs[63];
                prod = 128'(absval(op.lhs)) * 128'(absval(op.rhs));
                lim = neg ? MIN64 : MAX64;
                if (prod[127:64] != 0 || prod[63:0] > lim) r.st = ST_OVF;
                else res = neg ? (64'd0 - prod[63:0]) : prod[63:0];
            end
            F_SDIV, F_SREM: begin
                if (sb == 0) r.st = ST_DIV_ZERO;
                else if (sa == smin && sb == ONES) r.st = ST_DIV_OVF;
                else begin
                    q = absval(sa) / absval(sb);
                    rm = absval(sa) % absval(sb);
                    if (op.func == F_SDIV) res = (sa[63] ^ sb[63]) ? -q : q;
                    else res = sa[63] ? -rm : rm;
                end
            end
            F_UDIV, F_UREM: begin
                if (ub == 0) r.st = ST_DIV_ZERO;
                else res = (op.func == F_UDIV) ? ua / ub : ua % ub;
            end
            F_AND:  res = op.lhs & op.rhs;
            F_OR:   res = op.lhs | op.rhs;
            F_XOR:  res = op.lhs ^ op.rhs;
            F_SHL:  res = ua << amt;
            F_LSHR: res = ua >> amt;
            F_ASHR: res = 64'($signed(sa) >>> amt);
            F_EQ:   res = 64'(op.lhs == op.rhs);
            F_NE:   res = 64'(op.lhs != op.rhs);
            F_SLT:  res = 64'($signed(op.lhs) <  $signed(op.rhs));
            F_SLE:  res = 64'($signed(op.lhs) <= $signed(op.rhs));
            F_SGT:  res = 64'($signed(op.lhs) >  $signed(op.rhs));
            F_SGE:  res = 64'($signed(op.lhs) >= $signed(op.rhs));
            F_ULT:  res = 64'(op.lhs <  op.rhs);
            F_ULE:  res = 64'(op.lhs <= op.rhs);
            F_UGT:  res = 64'(op.lhs >  op.rhs);
            F_UGE:  res = 64'(op.lhs >= op.rhs);
            default: res = 64'd0;
        endcase
        // Arithmetic must also fit the selected width.
        if (r.st == ST_OK && op.func <= F_MUL && sign_ext(res, bits) != res) r.st = ST_OVF;
        if (r.st != ST_OK) res = 64'd0;
        else if (op.func <= F_ASHR) res = sign_ext(res, bits);
        r.value = res;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Operand values biased toward the edges of each width.
    function automatic logic [63:0] pick_operand(logic [1:0] w);
        logic [63:0] v;
        int unsigned bits;
        bits = width_of(w);
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = ONES;
            2: v = 64'd1 << (bits - 1);
            3: v = (64'd1 << (bits - 1)) - 1;
            4: v = 64'($urandom_range(0, 70));
            5: v = 64'd0 - 64'($urandom_range(1, 70));
            6: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_op(logic [4:0] f, logic [1:0] w, logic [63:0] a, logic [63:0] b);
        t_op op;
        op.func = f;
        op.wsel = w;
        op.lhs = a;
        op.rhs = b;
        op_queue.insert(op_queue.size(), op);
    endtask

    // Acceptance of an operation word, seen at the rising edge.
    bit in_taken;
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && op_ch.valid && op_ch.ready;
    end

    // Driver: presents words from the queue with random gaps.
    int  send_gap;
    t_op cur_op;
    always @(negedge i_clk) begin
        if (in_taken) begin
            result_queue.insert(result_queue.size(), alu_result(cur_op));
            send_gap = gap_len();
        end
        if (!op_ch.valid || in_taken) begin
            if (i_rst_n && !hold_sender && send_gap == 0 && op_queue.size() > 0) begin
                cur_op = op_queue.pop_front();
                op_ch.valid     <= 1'b1;
                op_ch.func      <= cur_op.func;
                op_ch.width_sel <= cur_op.wsel;
                op_ch.lhs_value <= cur_op.lhs;
                op_ch.rhs_value <= cur_op.rhs;
            end else begin
                op_ch.valid <= 1'b0;
                if (i_rst_n && !hold_sender && send_gap > 0) send_gap--;
            end
        end
    end

    // Result stall pattern on the output side.
    int stall_gap;
    always @(negedge i_clk) begin
        if (stall_gap > 0) begin
            stall_gap--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_gap = gap_len();
        end
    end

    // Monitor: checks each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (result_queue.size() == 0) begin
                $error("result word with no operation outstanding");
                fail_count++;
            end else begin
                want = result_queue.pop_front();
                if (res_ch.result_value !== want.value) begin
                    $error("result_value: expected %h, got %h", want.value,
                           res_ch.result_value);
                    fail_count++;
                end
                if (res_ch.status !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, res_ch.status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving either way.
    always @(posedge i_clk) begin
        if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [1:0]  w;
        logic [4:0]  f;
        int unsigned k;
        fail_count = 0;
        idle_cycles = 0;
        hold_sender = 1'b0;
        send_gap = 0;
        stall_gap = 0;
        i_rst_n = 1'b0;
        op_ch.valid = 1'b0;
        op_ch.func = '0;
        op_ch.width_sel = '0;
        op_ch.lhs_value = '0;
        op_ch.rhs_value = '0;
        res_ch.ready = 1'b0;

        // Directed words: extremes, faults, width code three, unused codes.
        add_op(F_ADD,  W_64, MAX64, 64'd1);
        add_op(F_SUB,  W_64, MIN64, 64'd1);
        add_op(F_ADD,  W_16, 64'h7fff, 64'd1);
        add_op(F_MUL,  W_64, MIN64, ONES);
        add_op(F_MUL,  W_64, MIN64, 64'd1);
        add_op(F_MUL,  W_32, 64'h10000, 64'h8000);
        add_op(F_SDIV, W_64, MIN64, ONES);
        add_op(F_SREM, W_16, 64'h8000, ONES);
        add_op(F_SDIV, W_32, 64'd7, 64'h1_0000_0000);
        add_op(F_SREM, W_64, 64'd0 - 64'd7, 64'd2);
        add_op(F_UDIV, W_16, ONES, 64'd3);
        add_op(F_UREM, W_32, ONES, 64'h1_0000_0000);
        add_op(F_SHL,  W_16, ONES, 64'd15);
        add_op(F_LSHR, W_32, ONES, 64'd63);
        add_op(F_ASHR, W_64, MIN64, 64'd63);
        add_op(F_XOR,  W_64_ALT, ONES, 64'h1234);
        add_op(F_AND,  W_16, ONES, MAX64);
        add_op(F_OR,   W_32, 64'd0, MIN64);
        add_op(5'd23,  W_16, ONES, ONES);
        add_op(5'd31,  W_64, ONES, ONES);
        for (k = F_EQ; k <= F_UGE; k++) add_op(5'(k), W_16, MIN64, MAX64);

        // Hold reset, then release it at a falling clock edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Random words; midway the sender drains the pipeline once.
        for (k = 0; k < N_RANDOM; k++) begin
            w = 2'($urandom_range(0, 3));
            f = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(23, 31))
                                             : 5'($urandom_range(0, 22));
            add_op(f, w, pick_operand(w), pick_operand(w));
            if (k == N_RANDOM / 2) begin
                while (op_queue.size() != 0 || op_ch.valid) @(negedge i_clk);
                hold_sender = 1'b1;
                while (result_queue.size() != 0) @(negedge i_clk);
                @(negedge i_clk);
                hold_sender = 1'b0;
            end
        end

        // Drain and let the pipeline settle.
        while (op_queue.size() != 0 || op_ch.valid || result_queue.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
